@@ sv/linear_probe_hash_set_assert.svh @@
// Assertion macros used by the checker file of the hash set.
`ifndef LINEAR_PROBE_HASH_SET_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_ASSERT_SVH

// Same-cycle implication, clocked on i_clk and held off during reset.
`define LPHS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash set check failed");

// Next-cycle implication, clocked on i_clk and held off during reset.
`define LPHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash set check failed");

`endif

@@ sv/lphs_pkg.sv @@
// Shared types and constants of the linear probing hash set.
package lphs_pkg;

    localparam int SLOTS      = 1024;
    localparam int OP_W       = 2;
    localparam int KEY_W      = 64;
    localparam int HASH_W     = 31;
    localparam int MARK_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int COUNT_W    = $clog2(SLOTS + 1);
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_HIT,
        SEL_FREE
    } t_slot_sel;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_FIRST,
        S_CHECK,
        S_CLEAR,
        S_POST
    } t_state;

    typedef struct packed {
        logic      load;
        logic      probe_start;
        logic      probe_step;
        logic      clr_step;
        logic      write_add;
        logic      write_remove;
        logic      count_clear;
        logic      set_result;
        t_status   res_status;
        t_slot_sel res_sel;
        logic      post;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic hash_zero;
        logic hit;
        logic empty;
        logic probe_last;
        logic free_any;
        logic full;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

@@ sv/lphs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module lphs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/lphs_ctrl.sv @@
// Controller state machine of the hash set: sequences sweeps, probes and results.
module lphs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  lphs_pkg::t_sts  i_sts,
    output lphs_pkg::t_cmd  o_cmd
);

    lphs_pkg::t_state r_state;
    lphs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lphs_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.res_status = lphs_pkg::ST_OK;
        o_cmd.res_sel    = lphs_pkg::SEL_ZERO;
        unique case (r_state)
            lphs_pkg::S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = lphs_pkg::S_IDLE;
                end
            end
            lphs_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lphs_pkg::S_DECODE;
                end
            end
            lphs_pkg::S_DECODE: begin
                priority if (i_sts.op == lphs_pkg::OP_CLEAR) begin
                    n_state = lphs_pkg::S_CLEAR;
                end else if (i_sts.hash_zero) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.res_status = lphs_pkg::ST_ABSENT;
                    n_state          = lphs_pkg::S_POST;
                end else begin
                    n_state = lphs_pkg::S_MOD;
                end
            end
            lphs_pkg::S_MOD: begin
                o_cmd.probe_start = 1'b1;
                n_state           = lphs_pkg::S_FIRST;
            end
            lphs_pkg::S_FIRST: begin
                n_state = lphs_pkg::S_CHECK;
            end
            lphs_pkg::S_CHECK: begin
                priority if (i_sts.hit) begin
                    o_cmd.set_result = 1'b1;
                    n_state          = lphs_pkg::S_POST;
                    unique case (i_sts.op)
                        lphs_pkg::OP_ADD: begin
                            o_cmd.res_status = lphs_pkg::ST_ABSENT;
                        end
                        lphs_pkg::OP_REMOVE: begin
                            o_cmd.write_remove = 1'b1;
                            o_cmd.res_sel      = lphs_pkg::SEL_HIT;
                        end
                        default: begin
                            o_cmd.res_sel = lphs_pkg::SEL_HIT;
                        end
                    endcase
                end else if (i_sts.empty || i_sts.probe_last) begin
                    o_cmd.set_result = 1'b1;
                    n_state          = lphs_pkg::S_POST;
                    priority if (i_sts.op != lphs_pkg::OP_ADD) begin
                        o_cmd.res_status = lphs_pkg::ST_ABSENT;
                    end else if (i_sts.full || !i_sts.free_any) begin
                        o_cmd.res_status = lphs_pkg::ST_FULL;
                    end else begin
                        o_cmd.write_add = 1'b1;
                        o_cmd.res_sel   = lphs_pkg::SEL_FREE;
                    end
                end else begin
                    o_cmd.probe_step = 1'b1;
                end
            end
            lphs_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.count_clear = 1'b1;
                    o_cmd.set_result  = 1'b1;
                    n_state           = lphs_pkg::S_POST;
                end
            end
            lphs_pkg::S_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = lphs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lphs_pkg::S_INIT;
            end
        endcase
    end

endmodule

@@ sv/lphs_dp.sv @@
// Datapath of the hash set: item registers, start slot, probe, tables, result.
module lphs_dp #(
    parameter int KEY_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [lphs_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [lphs_pkg::OP_W-1:0]        i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [lphs_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  lphs_pkg::t_cmd                   i_cmd,
    output lphs_pkg::t_sts                   o_sts
);

    localparam int SLOTS    = lphs_pkg::SLOTS;
    localparam int SW       = lphs_pkg::SLOT_W;
    localparam int CW       = lphs_pkg::COUNT_W;
    localparam int KW       = 8 * KEY_BYTES;
    localparam int HW       = lphs_pkg::HASH_W;
    localparam int MW       = lphs_pkg::MARK_W;
    localparam int OSLOT_W  = lphs_pkg::SLOT_W;
    localparam int OCOUNT_W = lphs_pkg::COUNT_W;
    localparam int OSTAT_W  = lphs_pkg::STATUS_W;
    localparam int OUT_W    = lphs_pkg::OUT_DATA_W;

    lphs_pkg::t_op    r_op;
    logic [KW-1:0]    r_key;
    logic [HW-1:0]    r_hash;
    logic [SW-1:0]    start_slot;

    logic [SW-1:0]    r_j;
    logic [SW-1:0]    n_j;
    logic [SW-1:0]    r_n;
    logic [SW-1:0]    r_free;
    logic             r_free_valid;
    logic [SW-1:0]    r_clr;
    logic [CW-1:0]    r_count;

    lphs_pkg::t_status r_res_status;
    logic [SW-1:0]     r_res_slot;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [MW-1:0]    mark_rd;
    logic [KW-1:0]    key_rd;
    logic             cur_free;
    logic [SW-1:0]    free_idx;
    logic [CW+2:0]    need;

    logic             mark_we;
    logic [SW-1:0]    mark_waddr;
    logic [MW-1:0]    mark_wdata;

    // Item registers; only the low key bytes take part.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= lphs_pkg::t_op'(i_s_tuser);
            r_key  <= i_s_tdata[KW-1:0];
            r_hash <= i_s_tdata[lphs_pkg::KEY_W +: HW];
        end
    end

    // Start slot: hash modulo the slot count, which is a power of two.
    assign start_slot = r_hash[SW-1:0];

    // Probe index; the RAMs read at the next index so data lines up with r_j.
    always_comb begin
        n_j = r_j;
        if (i_cmd.probe_start) begin
            n_j = start_slot;
        end else if (i_cmd.probe_step) begin
            n_j = (r_j == SW'(SLOTS - 1)) ? '0 : r_j + 1'b1;
        end
    end

    assign cur_free = (mark_rd == '0) || mark_rd[MW-1];
    assign free_idx = r_free_valid ? r_free : r_j;

    always_ff @(posedge i_clk) begin
        r_j <= n_j;
        if (i_cmd.probe_start) begin
            r_n          <= '0;
            r_free_valid <= 1'b0;
        end else if (i_cmd.probe_step) begin
            r_n <= r_n + 1'b1;
            if (cur_free && !r_free_valid) begin
                r_free_valid <= 1'b1;
                r_free       <= r_j;
            end
        end
    end

    // Clear sweep counter and live entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= (r_clr == SW'(SLOTS - 1)) ? '0 : r_clr + 1'b1;
            end
            priority if (i_cmd.count_clear) begin
                r_count <= '0;
            end else if (i_cmd.write_add) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.write_remove && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Table writes.
    always_comb begin
        mark_we    = i_cmd.clr_step | i_cmd.write_add | i_cmd.write_remove;
        mark_waddr = r_clr;
        mark_wdata = '0;
        priority if (i_cmd.write_add) begin
            mark_waddr = free_idx;
            mark_wdata = {1'b0, r_hash};
        end else if (i_cmd.write_remove) begin
            mark_waddr = r_j;
            mark_wdata = {1'b1, r_hash};
        end else begin
            mark_waddr = r_clr;
        end
    end

    lphs_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (n_j),
        .o_rdata (mark_rd)
    );

    lphs_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_add),
        .i_waddr (free_idx),
        .i_wdata (r_key),
        .i_raddr (n_j),
        .o_rdata (key_rd)
    );

    // Result hold and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_result) begin
            r_res_status <= i_cmd.res_status;
            unique case (i_cmd.res_sel)
                lphs_pkg::SEL_HIT:  r_res_slot <= r_j;
                lphs_pkg::SEL_FREE: r_res_slot <= free_idx;
                default:            r_res_slot <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_data <= OUT_W'({OCOUNT_W'(r_count), OSLOT_W'(r_res_slot),
                                  OSTAT_W'(r_res_status)});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // An add is refused when twice (count + 3) exceeds the slot count.
    assign need = ((CW + 3)'(r_count) + (CW + 3)'(3)) << 1;

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.hash_zero  = (r_hash == '0);
        o_sts.hit        = (mark_rd == {1'b0, r_hash}) && (key_rd == r_key);
        o_sts.empty      = (mark_rd == '0);
        o_sts.probe_last = (r_n == SW'(SLOTS - 1));
        o_sts.free_any   = r_free_valid | cur_free;
        o_sts.full       = need > (CW + 3)'(SLOTS);
        o_sts.clr_last   = (r_clr == SW'(SLOTS - 1));
        o_sts.out_free   = !r_out_valid || i_m_tready;
    end

endmodule

@@ sv/linear_probe_hash_set.sv @@
// Top level of the linear probing hash set: controller plus datapath.
//
//  Channel  | Direction | tdata (low bit up)                      | tuser
//  ---------+-----------+-----------------------------------------+-----------
//  s_axis   | in        | key[63:0], key_hash[94:64], pad to 96   | operation
//  m_axis   | out       | status[1:0], slot[11:2], entry_count    | none
//           |           | [22:12], pad to 24                      |
//
// Add, remove and contains pass from accept through decode, the start slot and the probe
// to the result (the mark and key RAMs give one probe per cycle); the next transfer is
// taken in the cycle after the result is posted.
// Clear sweeps one mark a cycle over every slot; a zero hash skips the probe.
// After reset the block clears all SLOTS (1024) hash marks with s_axis_tready low.
// A result waits in the output register while m_axis_tready is low; the next item is
// already accepted, but its result is held and s_axis_tready stays low until it frees.
module linear_probe_hash_set #(
    parameter int KEY_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key[63:0], key_hash[94:64], zero pad [95]
    input  logic [lphs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation[1:0]
    input  logic [lphs_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], slot[11:2], entry_count[22:12], zero pad [23]
    output logic [lphs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // Commands from the controller and status back from the datapath.
    lphs_pkg::t_cmd cmd;
    lphs_pkg::t_sts sts;

    // The controller owns sequencing: it accepts one transfer at a time, starts the
    // probe at the home slot, walks the probe sequence and chooses the result.
    lphs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the tables, the probe index and the output register.
    lphs_dp #(
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

@@ sv/lphs_checker.sv @@
// Port-level checker of the hash set and its bind to the top level.
`include "linear_probe_hash_set_assert.svh"

module lphs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [lphs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic [lphs_pkg::OP_W-1:0]        s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lphs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic [lphs_pkg::STATUS_W-1:0] status;
    logic [lphs_pkg::SLOT_W-1:0]   slot;
    logic                          in_xfer;

    assign status  = m_axis_tdata[lphs_pkg::STATUS_W-1:0];
    assign slot    = m_axis_tdata[lphs_pkg::STATUS_W +: lphs_pkg::SLOT_W];
    assign in_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1 || s_axis_tuser != '1
                     || 1'b1);

    // A result that is not a success never names a slot.
    `LPHS_ASSERT_NOW(a_slot_zero, m_axis_tvalid && status != lphs_pkg::ST_OK, slot == '0)
    // Only success, absent and full codes are produced.
    `LPHS_ASSERT_NOW(a_status_code, m_axis_tvalid, status != 2'd3)
    // One item at a time: after a transfer in, the input side is closed next cycle.
    `LPHS_ASSERT_NEXT(a_one_item, in_xfer, !s_axis_tready)
    // A stalled result holds.
    `LPHS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                      m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);
